@@ rtl/core/pidu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidu_pkg
// Shared types and constants of the incremental PID update block.
// ----------------------------------------------------------------------------
package pidu_pkg;

  localparam int ERR_W      = 16;
  localparam int TICK_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

  // integer part of the derivative numerator, quotient bits of the divider
  localparam int DIV_STEPS = 27;
  localparam int DIV_CNT_W = 5;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic div_load;
    logic div_step;
    logic frac;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

endpackage

@@ rtl/core/pidu_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidu_in_if
// Input channel: error sample and elapsed tick count.
// ----------------------------------------------------------------------------
interface pidu_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pidu_pkg::ERR_W-1:0]   error_sample;
  logic        [pidu_pkg::TICK_W-1:0]  elapsed_ticks;

  modport source (output valid, output error_sample, output elapsed_ticks, input ready);
  modport sink   (input valid, input error_sample, input elapsed_ticks, output ready);
endinterface

@@ rtl/core/pidu_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidu_out_if
// Output channel: saturated drive value and clip flag.
// ----------------------------------------------------------------------------
interface pidu_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pidu_pkg::OUT_W-1:0]  drive_value;
  logic                               saturated;

  modport source (output valid, output drive_value, output saturated, input ready);
  modport sink   (input valid, input drive_value, input saturated, output ready);
endinterface

@@ rtl/core/incremental_pid_update_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_pid_update_top
// Velocity-form PID update with exact truncation and 32-bit saturation.
// ----------------------------------------------------------------------------
// One transaction is in flight at a time. An accepted input runs through two
// multiply steps, a divider load, 27 steps of a one-bit-per-cycle restoring
// divider that scales the derivative term by the tick count, a fraction step
// and a final sum and clip step into the output register; the next input can
// be taken the cycle after that final step. A result waiting in the output
// register holds only the final step. Gains are to be written through
// cfg_wr_en, cfg_index and cfg_data while the block is idle; the block itself
// does not enforce this. Unknown indexes are dropped.
// ----------------------------------------------------------------------------
module incremental_pid_update_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_wr_en,
  input  logic        [pidu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [pidu_pkg::CFG_DATA_W-1:0]  cfg_data,
  pidu_in_if.sink                                 in_ch,
  pidu_out_if.source                              out_ch
);

  pidu_pkg::cmd_t  cmd;
  pidu_pkg::stat_t stat;

  pidu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pidu_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_error    (in_ch.error_sample),
    .in_ticks    (in_ch.elapsed_ticks),
    .cmd         (cmd),
    .stat        (stat),
    .drive_value (out_ch.drive_value),
    .saturated   (out_ch.saturated)
  );

endmodule

@@ rtl/core/pidu_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidu_datapath
// Gain registers, controller history, multipliers, serial divider for the
// derivative scale, exact truncation and 32-bit saturation.
// ----------------------------------------------------------------------------
module pidu_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_wr_en,
  input  logic        [pidu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [pidu_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic signed [pidu_pkg::ERR_W-1:0]       in_error,
  input  logic        [pidu_pkg::TICK_W-1:0]      in_ticks,
  input  pidu_pkg::cmd_t                          cmd,
  output pidu_pkg::stat_t                         stat,
  output logic signed [pidu_pkg::OUT_W-1:0]       drive_value,
  output logic                                    saturated
);

  localparam int A_W  = 50;
  localparam int D_W  = 51;
  localparam int DQ_W = pidu_pkg::DIV_STEPS;
  localparam int QA_W = A_W - 24;
  localparam int F_W  = 41;
  localparam int S_W  = 36;

  logic        [15:0] gain_p;
  logic        [15:0] gain_i;
  logic        [15:0] gain_d;

  logic signed [15:0] prev_err;
  logic signed [15:0] old_err;
  logic signed [31:0] prev_out;

  logic signed [15:0] err;
  logic        [15:0] ticks;

  logic        [31:0] m1;
  logic        [31:0] m2;
  logic signed [33:0] m3;

  logic signed [A_W-1:0] acc_a;
  logic signed [D_W-1:0] acc_d;

  logic        [DQ_W-1:0] dvd;
  logic        [15:0]     rem;
  logic                   neg;
  logic [pidu_pkg::DIV_CNT_W-1:0] cnt;

  logic signed [DQ_W-1:0] qd;
  logic        [F_W-1:0]  frac;

  logic signed [16:0] diff1;
  logic signed [17:0] diff2;
  logic signed [A_W-1:0] prod_a;
  logic signed [A_W-1:0] m3_ext;
  logic signed [D_W-1:0] prod_d;
  logic        [15:0]    tt;
  logic        [DQ_W-1:0] dq;
  logic signed [QA_W-1:0] qa;
  logic        [16:0]    shifted;
  logic                  qbit;
  logic        [15:0]    rd_hi;
  logic        [F_W-1:0] den;
  logic                  ge;
  logic                  fnz;
  logic signed [S_W-1:0] prev_sel;
  logic signed [S_W-1:0] sum;
  logic signed [S_W-1:0] sum_adj;
  logic                  sat_hi;
  logic                  sat_lo;

  assign diff1  = {err[15], err} - {prev_err[15], prev_err};
  assign diff2  = {{2{err[15]}}, err} - {prev_err[15], prev_err, 1'b0}
                + {{2{old_err[15]}}, old_err};
  assign prod_a = $signed({1'b0, m1}) * err;
  assign m3_ext = {{(A_W-34){m3[33]}}, m3};
  assign prod_d = $signed({1'b0, m2}) * diff2;

  assign tt = (ticks == '0) ? 16'd1 : ticks;
  assign dq = acc_d[D_W-1:24];
  assign qa = acc_a[A_W-1:24];

  assign shifted = {rem, dvd[DQ_W-1]};
  assign qbit    = (shifted >= {1'b0, tt});
  assign stat.div_done = (cnt == pidu_pkg::DIV_CNT_W'(pidu_pkg::DIV_STEPS - 1));

  assign rd_hi = neg ? (tt - 16'd1 - rem) : rem;

  assign den      = {1'b0, tt, 24'b0};
  assign ge       = (frac >= den);
  assign fnz      = (frac != '0) && (frac != den);
  assign prev_sel = (err == '0) ? '0 : S_W'(prev_out);
  assign sum      = prev_sel + S_W'(qa) + S_W'(qd) + S_W'(ge);
  assign sum_adj  = (fnz && sum[S_W-1]) ? sum + S_W'(1) : sum;
  assign sat_hi   = !sum_adj[S_W-1] && (sum_adj[S_W-2:31] != '0);
  assign sat_lo   = sum_adj[S_W-1] && (sum_adj[S_W-2:31] != '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= pidu_pkg::GAIN_RESET;
      gain_i <= pidu_pkg::GAIN_RESET;
      gain_d <= pidu_pkg::GAIN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pidu_pkg::REG_GAIN_P: gain_p <= cfg_data;
        pidu_pkg::REG_GAIN_I: gain_i <= cfg_data;
        pidu_pkg::REG_GAIN_D: gain_d <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
      old_err  <= '0;
      prev_out <= '0;
    end else if (cmd.finish) begin
      prev_err <= err;
      old_err  <= prev_err;
      if (sat_hi) begin
        prev_out <= 32'sh7FFF_FFFF;
      end else if (sat_lo) begin
        prev_out <= 32'sh8000_0000;
      end else begin
        prev_out <= sum_adj[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err   <= in_error;
      ticks <= in_ticks;
    end
    if (cmd.mul1) begin
      m1 <= gain_p * gain_i;
      m2 <= gain_p * gain_d;
      m3 <= $signed({1'b0, gain_p}) * diff1;
    end
    if (cmd.mul2) begin
      acc_a <= prod_a + {m3_ext[A_W-9:0], 8'b0};
      acc_d <= (ticks == '0) ? '0 : prod_d;
    end
    if (cmd.div_load) begin
      neg <= dq[DQ_W-1];
      dvd <= dq[DQ_W-1] ? ~dq : dq;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= qbit ? 16'(shifted - {1'b0, tt}) : shifted[15:0];
      dvd <= {dvd[DQ_W-2:0], qbit};
      cnt <= cnt + 1'b1;
    end
    if (cmd.frac) begin
      qd   <= neg ? $signed(~dvd) : $signed(dvd);
      frac <= F_W'(acc_a[23:0]) * F_W'(tt) + F_W'({rd_hi, acc_d[23:0]});
    end
    if (cmd.finish) begin
      saturated <= sat_hi || sat_lo;
      if (sat_hi) begin
        drive_value <= 32'sh7FFF_FFFF;
      end else if (sat_lo) begin
        drive_value <= 32'sh8000_0000;
      end else begin
        drive_value <= sum_adj[31:0];
      end
    end
  end

endmodule

@@ rtl/core/pidu_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidu_ctrl
// Sequencer for one update and the output valid flag.
// ----------------------------------------------------------------------------
module pidu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output pidu_pkg::cmd_t   cmd,
  input  pidu_pkg::stat_t  stat
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL1  = 7'b0000010,
    S_MUL2  = 7'b0000100,
    S_DIVLD = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_FRAC  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   finish;

  assign in_ready = (state == S_IDLE);
  assign finish   = (state == S_FIN) && (!out_valid || out_ready);

  assign cmd.load     = in_valid && in_ready;
  assign cmd.mul1     = (state == S_MUL1);
  assign cmd.mul2     = (state == S_MUL2);
  assign cmd.div_load = (state == S_DIVLD);
  assign cmd.div_step = (state == S_DIV);
  assign cmd.frac     = (state == S_FRAC);
  assign cmd.finish   = finish;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_DIVLD;
      S_DIVLD: state_next = S_DIV;
      S_DIV:   if (stat.div_done) state_next = S_FRAC;
      S_FRAC:  state_next = S_FIN;
      S_FIN:   if (finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/core/pidu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidu_checker
// Port-level checks of the incremental PID update block.
// ----------------------------------------------------------------------------
module pidu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] drive_value,
  input logic        saturated
);

  ast_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_value) && $stable(saturated))
    else $error("output transaction dropped or changed while stalled");

  ast_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  ast_sat_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> drive_value == 32'h7FFF_FFFF || drive_value == 32'h8000_0000)
    else $error("saturated result is not a range limit");

  ast_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind incremental_pid_update_top pidu_checker u_pidu_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .drive_value (out_ch.drive_value),
  .saturated   (out_ch.saturated)
);
